FILE: design/shs_pkg.sv
// shared types and constants for the stepper homing sequencer
// no dependencies; compiled before the interfaces and modules

package shs_pkg;

  // field widths
  localparam int unsigned StepW  = 16;
  localparam int unsigned DelayW = 20;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 20;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_BACKOFF_STEPS    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_OFFSET_STEPS     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_FAST_DELAY_TICKS = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SLOW_DELAY_TICKS = 2'd3;

  // configuration register reset values
  localparam logic [StepW-1:0]  BACKOFF_RST = '0;
  localparam logic [StepW-1:0]  OFFSET_RST  = '0;
  localparam logic [DelayW-1:0] FAST_DLY_RST = DelayW'(1);
  localparam logic [DelayW-1:0] SLOW_DLY_RST = DelayW'(1);

  // configuration registers as seen by the sequencer
  typedef struct packed {
    logic [StepW-1:0]  backoff_steps;
    logic [StepW-1:0]  offset_steps;
    logic [DelayW-1:0] fast_delay_ticks;
    logic [DelayW-1:0] slow_delay_ticks;
  } shs_cfg_t;

  // one tick word
  typedef struct packed {
    logic start_req;
    logic endstop_filtered;
    logic endstop_raw;
  } shs_in_t;

  // one result word
  typedef struct packed {
    logic step_pulse;
    logic direction_ccw;
    logic motor_enable;
    logic busy_res;
    logic homed;
  } shs_out_t;

  // handshake group between top level and sequencer
  typedef struct packed {
    logic in_valid;
    logic out_ready;
  } shs_hs_in_t;

  typedef struct packed {
    logic in_ready;
    logic out_valid;
  } shs_hs_out_t;

endpackage

FILE: design/shs_in_if.sv
// tick channel: valid, ready and the input word fields
// no dependencies

interface shs_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic endstop_filtered;
  logic endstop_raw;

  modport source (output valid, output start_req, output endstop_filtered,
                  output endstop_raw, input ready);
  modport sink (input valid, input start_req, input endstop_filtered,
                input endstop_raw, output ready);
endinterface

FILE: design/shs_out_if.sv
// result channel: valid, ready and the result word fields
// no dependencies

interface shs_out_if;
  logic valid;
  logic ready;
  logic step_pulse;
  logic direction_ccw;
  logic motor_enable;
  logic busy_res;
  logic homed;

  modport source (output valid, output step_pulse, output direction_ccw,
                  output motor_enable, output busy_res, output homed, input ready);
  modport sink (input valid, input step_pulse, input direction_ccw,
                input motor_enable, input busy_res, input homed, output ready);
endinterface

FILE: design/shs_sequencer.sv
// homing phase machine: counters, phase, homed flag and the result register
// depends on shs_pkg

module shs_sequencer
  import shs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  shs_cfg_t    cfg_i,
  input  shs_hs_in_t  hs_i,
  input  shs_in_t     in_data_i,
  output shs_hs_out_t hs_o,
  output shs_out_t    out_data_o
);

  typedef enum logic [2:0] {
    PH_IDLE          = 3'd0,
    PH_FAST_APPROACH = 3'd1,
    PH_BACKOFF       = 3'd2,
    PH_SLOW_APPROACH = 3'd3,
    PH_OFFSET        = 3'd4
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [StepW-1:0]   steps_q, steps_d;
  logic [DelayW-1:0]  delay_q, delay_d;
  logic               homed_q, homed_d;
  logic               step;
  logic               out_valid_q, out_valid_d;
  shs_out_t           out_q, out_d;
  logic               in_ready;
  logic               accept;

  // a new word enters whenever the result register is free or being drained
  assign in_ready = !out_valid_q || hs_i.out_ready;
  assign accept   = hs_i.in_valid && in_ready;

  // next state for one tick
  always_comb begin
    phase_d = phase_q;
    steps_d = steps_q;
    delay_d = delay_q;
    homed_d = homed_q;
    step    = 1'b0;
    if (phase_q != PH_IDLE && phase_q != PH_FAST_APPROACH && phase_q != PH_BACKOFF &&
        phase_q != PH_SLOW_APPROACH && phase_q != PH_OFFSET) begin
      // stray code falls back to idle, or starts a run when start_req is set
      phase_d = PH_IDLE;
      if (in_data_i.start_req) begin
        homed_d = 1'b0;
        delay_d = '0;
        phase_d = in_data_i.endstop_filtered ? PH_BACKOFF : PH_FAST_APPROACH;
        steps_d = in_data_i.endstop_filtered ? cfg_i.backoff_steps : '0;
      end
    end else if (phase_q == PH_IDLE) begin
      // start sets the run up, no step this tick
      if (in_data_i.start_req) begin
        homed_d = 1'b0;
        delay_d = '0;
        phase_d = in_data_i.endstop_filtered ? PH_BACKOFF : PH_FAST_APPROACH;
        steps_d = in_data_i.endstop_filtered ? cfg_i.backoff_steps : '0;
      end
    end else if (delay_q != '0) begin
      // wait ticks after a step
      delay_d = delay_q - DelayW'(1);
    end else begin
      unique case (phase_q)
        PH_FAST_APPROACH: begin
          if (in_data_i.endstop_raw) begin
            phase_d = PH_BACKOFF;
            steps_d = cfg_i.backoff_steps;
          end else begin
            step    = 1'b1;
            delay_d = cfg_i.fast_delay_ticks;
          end
        end
        PH_BACKOFF: begin
          if (steps_q == '0) begin
            phase_d = PH_SLOW_APPROACH;
          end else begin
            step    = 1'b1;
            steps_d = steps_q - StepW'(1);
            delay_d = cfg_i.fast_delay_ticks;
          end
        end
        PH_SLOW_APPROACH: begin
          if (in_data_i.endstop_raw) begin
            phase_d = PH_OFFSET;
            steps_d = cfg_i.offset_steps;
          end else begin
            step    = 1'b1;
            delay_d = cfg_i.slow_delay_ticks;
          end
        end
        PH_OFFSET: begin
          if (steps_q == '0) begin
            phase_d = PH_IDLE;
            homed_d = 1'b1;
          end else begin
            step    = 1'b1;
            steps_d = steps_q - StepW'(1);
            delay_d = cfg_i.slow_delay_ticks;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  // result word reflects the state after this tick
  always_comb begin
    out_d.step_pulse    = step;
    out_d.direction_ccw = (phase_d == PH_FAST_APPROACH) || (phase_d == PH_SLOW_APPROACH);
    out_d.motor_enable  = (phase_d != PH_IDLE);
    out_d.busy_res      = (phase_d != PH_IDLE);
    out_d.homed         = homed_d;
  end

  // result register valid: set on accept, cleared when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (hs_i.out_ready) begin
      out_valid_d = 1'b0;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      steps_q     <= '0;
      delay_q     <= '0;
      homed_q     <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q <= phase_d;
        steps_q <= steps_d;
        delay_q <= delay_d;
        homed_q <= homed_d;
        out_q   <= out_d;
      end
    end
  end

  assign hs_o.in_ready  = in_ready;
  assign hs_o.out_valid = out_valid_q;
  assign out_data_o     = out_q;

endmodule

FILE: design/stepper_homing_sequencer.sv
// top level: configuration registers, channel wiring and the phase machine
// depends on shs_pkg, shs_in_if, shs_out_if and shs_sequencer
//
//   channel   dir  handshake              word
//   in_s      in   valid / ready          start_req, endstop_filtered, endstop_raw
//   out_m     out  valid / ready          step_pulse, direction_ccw, motor_enable,
//                                         busy_res, homed
//   cfg       in   cfg_we_i (no ready)    cfg_idx_i, cfg_wdata_i
//
// one tick word is taken per cycle while ready is high; its result word sits
// in the result register on the next cycle, set by a single registered pass
// through the phase machine. in_s.ready stays high while the result register is
// empty or being read, so a stalled sink holds one word and then stops the source.
// reset puts the machine in idle with counters and homed cleared, and the
// configuration registers at their defaults.

module stepper_homing_sequencer
  import shs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  shs_in_if.sink              in_s,
  shs_out_if.source           out_m,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  shs_cfg_t    cfg_q;
  shs_hs_in_t  hs_in;
  shs_hs_out_t hs_out;
  shs_in_t     in_data;
  shs_out_t    out_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.backoff_steps    <= BACKOFF_RST;
      cfg_q.offset_steps     <= OFFSET_RST;
      cfg_q.fast_delay_ticks <= FAST_DLY_RST;
      cfg_q.slow_delay_ticks <= SLOW_DLY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BACKOFF_STEPS:    cfg_q.backoff_steps    <= cfg_wdata_i[StepW-1:0];
        REG_OFFSET_STEPS:     cfg_q.offset_steps     <= cfg_wdata_i[StepW-1:0];
        REG_FAST_DELAY_TICKS: cfg_q.fast_delay_ticks <= cfg_wdata_i[DelayW-1:0];
        REG_SLOW_DELAY_TICKS: cfg_q.slow_delay_ticks <= cfg_wdata_i[DelayW-1:0];
        default: ;
      endcase
    end
  end

  // channel word packing
  assign in_data.start_req        = in_s.start_req;
  assign in_data.endstop_filtered = in_s.endstop_filtered;
  assign in_data.endstop_raw      = in_s.endstop_raw;
  assign hs_in.in_valid           = in_s.valid;
  assign hs_in.out_ready          = out_m.ready;

  shs_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .hs_i       (hs_in),
    .in_data_i  (in_data),
    .hs_o       (hs_out),
    .out_data_o (out_data)
  );

  // result channel
  assign in_s.ready          = hs_out.in_ready;
  assign out_m.valid         = hs_out.out_valid;
  assign out_m.step_pulse    = out_data.step_pulse;
  assign out_m.direction_ccw = out_data.direction_ccw;
  assign out_m.motor_enable  = out_data.motor_enable;
  assign out_m.busy_res      = out_data.busy_res;
  assign out_m.homed         = out_data.homed;

endmodule
